### rtl/dtiv_pkg.sv
package dtiv_pkg;

  // Field widths of one item and one result.
  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int DiffW  = 23;

  localparam int MaxYearDefault = 9999;

  // Serial day numbers for any 14-bit year stay below 2**23.
  localparam int SerW = 23;

  // Quotient widths for the leap year count.
  localparam int QW     = YearW - 2;
  localparam int Div25W = QW - 4;
  // Width of the leap year count (up to 4096).
  localparam int LeapW  = QW + 1;

  // Reciprocal of 25 scaled by 2**17. It is exact for every QW-bit numerator.
  localparam int RecipShift = 17;
  localparam logic [12:0] Recip25 = 13'd5243;

  localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthMar = MonthW'(3);
  localparam logic [MonthW-1:0] MonthApr = MonthW'(4);
  localparam logic [MonthW-1:0] MonthMay = MonthW'(5);
  localparam logic [MonthW-1:0] MonthJun = MonthW'(6);
  localparam logic [MonthW-1:0] MonthJul = MonthW'(7);
  localparam logic [MonthW-1:0] MonthAug = MonthW'(8);
  localparam logic [MonthW-1:0] MonthSep = MonthW'(9);
  localparam logic [MonthW-1:0] MonthOct = MonthW'(10);
  localparam logic [MonthW-1:0] MonthNov = MonthW'(11);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic            valid;
    logic            ok;
    logic [SerW-1:0] serial;
  } lane_res_t;

  // Floor of q / 25 by multiplication with the scaled reciprocal.
  function automatic logic [Div25W-1:0] div25(input logic [QW-1:0] q);
    logic [QW+13-1:0] p;
    p = (QW+13)'(q) * (QW+13)'(Recip25);
    return p[RecipShift+Div25W-1:RecipShift];
  endfunction

  // Days in a month; zero for codes that are no month.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      MonthFeb: len = leap ? DayW'(29) : DayW'(28);
      MonthApr, MonthJun, MonthSep, MonthNov: len = DayW'(30);
      MonthJan, MonthMar, MonthMay, MonthJul,
      MonthAug, MonthOct, MonthDec: len = DayW'(31);
      default: len = '0;
    endcase
    return len;
  endfunction

  // Days in the months before month m of a common year.
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] dbm;
    unique case (m)
      MonthJan: dbm = 9'd0;
      MonthFeb: dbm = 9'd31;
      MonthMar: dbm = 9'd59;
      MonthApr: dbm = 9'd90;
      MonthMay: dbm = 9'd120;
      MonthJun: dbm = 9'd151;
      MonthJul: dbm = 9'd181;
      MonthAug: dbm = 9'd212;
      MonthSep: dbm = 9'd243;
      MonthOct: dbm = 9'd273;
      MonthNov: dbm = 9'd304;
      MonthDec: dbm = 9'd334;
      default:  dbm = 9'd0;
    endcase
    return dbm;
  endfunction

endpackage

### rtl/date_interval_in_days.sv
// Date interval in days.
// An item carries two proleptic Gregorian dates, a start (from_*) and an end
// (to_*), each as year, month and day. The block returns the end serial day
// number minus the start serial day number on day_difference_o.
// Input channel: an item is accepted at a rising edge where start_i is high
// and busy_o is low. The pipeline never stalls, so busy_o stays low and an
// item may be offered in every cycle.
// Output channel: done_o is high for exactly one cycle per item, with the
// result on day_difference_o and invalid_date_o in that cycle. Results leave
// in the order their items came in. The receiver cannot hold them off.
// Each item passes the first lane stage, the second lane stage and the merge stage
// in that order; done_o rises as the merge stage takes it. There are two register
// stages per date lane, then one merge stage. Throughput is one item per cycle.
// A bad year, month or day in either date sets invalid_date_o and forces the
// difference to zero. A difference beyond the result width saturates.
// Reset clears all stage valid flags, so nothing in flight is delivered.
module date_interval_in_days #(
  parameter int MaxYear = dtiv_pkg::MaxYearDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [dtiv_pkg::YearW-1:0]         from_year_i,
  input  logic [dtiv_pkg::MonthW-1:0]        from_month_i,
  input  logic [dtiv_pkg::DayW-1:0]          from_day_i,
  input  logic [dtiv_pkg::YearW-1:0]         to_year_i,
  input  logic [dtiv_pkg::MonthW-1:0]        to_month_i,
  input  logic [dtiv_pkg::DayW-1:0]          to_day_i,
  output logic                               done_o,
  output logic signed [dtiv_pkg::DiffW-1:0]  day_difference_o,
  output logic                               invalid_date_o
);

  // Every stage advances each cycle, so the block never refuses an item.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  dtiv_pkg::lane_res_t from_res, to_res;

  // The two dates go through identical lanes side by side.
  dtiv_lane #(
    .MaxYear(MaxYear)
  ) u_from_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .year_i (from_year_i),
    .month_i(from_month_i),
    .day_i  (from_day_i),
    .res_o  (from_res)
  );

  dtiv_lane #(
    .MaxYear(MaxYear)
  ) u_to_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .year_i (to_year_i),
    .month_i(to_month_i),
    .day_i  (to_day_i),
    .res_o  (to_res)
  );

  // The merge stage forms the difference and registers the result.
  dtiv_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .from_i          (from_res),
    .to_i            (to_res),
    .done_o          (done_o),
    .day_difference_o(day_difference_o),
    .invalid_date_o  (invalid_date_o)
  );

endmodule

### rtl/dtiv_lane.sv
// One date to its serial day number, in two register stages.
module dtiv_lane #(
  parameter int MaxYear = dtiv_pkg::MaxYearDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [dtiv_pkg::YearW-1:0]   year_i,
  input  logic [dtiv_pkg::MonthW-1:0]  month_i,
  input  logic [dtiv_pkg::DayW-1:0]    day_i,
  output dtiv_pkg::lane_res_t          res_o
);

  localparam int YW = dtiv_pkg::YearW;
  localparam int QW = dtiv_pkg::QW;
  localparam int DW = dtiv_pkg::Div25W;
  localparam int LW = dtiv_pkg::LeapW;
  localparam int SW = dtiv_pkg::SerW;

  // Stage 1: range checks, leap test and the divisions by 4, 100 and 400.
  logic [YW-1:0] prev;
  logic [QW-1:0] y4, y16, q4;
  logic [DW-1:0] d100, d400;
  logic          div4, cent, quad, leap, ok;
  logic [dtiv_pkg::DayW-1:0] len;

  always_comb begin
    prev = year_i - YW'(1);
    q4   = prev[YW-1:2];
    d100 = dtiv_pkg::div25(q4);
    d400 = dtiv_pkg::div25(QW'(prev[YW-1:4]));
    y4   = year_i[YW-1:2];
    y16  = QW'(year_i[YW-1:4]);
    div4 = (year_i[1:0] == 2'b00);
    cent = div4 && (QW'(QW'(dtiv_pkg::div25(y4)) * QW'(25)) == y4);
    quad = (year_i[3:0] == 4'b0000) &&
           (QW'(QW'(dtiv_pkg::div25(y16)) * QW'(25)) == y16);
    leap = div4 && (!cent || quad);
    len  = dtiv_pkg::month_len(month_i, leap);
    ok   = (year_i != '0) && ({2'b00, year_i} <= 16'(MaxYear)) &&
           (len != '0) && (day_i != '0) && (day_i <= len);
  end

  logic                        valid1_q;
  logic                        ok1_q, leap1_q;
  logic [YW-1:0]               year1_q;
  logic [dtiv_pkg::MonthW-1:0] month1_q;
  logic [dtiv_pkg::DayW-1:0]   day1_q;
  logic [QW-1:0]               q4_q;
  logic [DW-1:0]               d100_q, d400_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ok1_q    <= ok;
    leap1_q  <= leap;
    year1_q  <= year_i;
    month1_q <= month_i;
    day1_q   <= day_i;
    q4_q     <= q4;
    d100_q   <= d100;
    d400_q   <= d400;
  end

  // Stage 2: add up the serial day number.
  logic [LW-1:0] leaps;
  logic [SW-1:0] serial_d;
  logic          adj;

  always_comb begin
    leaps    = LW'(q4_q) - LW'(d100_q) + LW'(d400_q) + LW'(1);
    adj      = leap1_q && (month1_q > dtiv_pkg::MonthFeb);
    serial_d = SW'(day1_q) + SW'(dtiv_pkg::days_before(month1_q)) + SW'(adj) +
               SW'(year1_q) * SW'(365) + SW'(leaps);
  end

  logic          valid2_q, ok2_q;
  logic [SW-1:0] serial_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else begin
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok2_q    <= ok1_q;
    serial_q <= serial_d;
  end

  assign res_o.valid  = valid2_q;
  assign res_o.ok     = ok2_q;
  assign res_o.serial = serial_q;

endmodule

### rtl/dtiv_merge.sv
// End serial minus start serial, saturated to the result width; zero on a bad date.
module dtiv_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dtiv_pkg::lane_res_t                from_i,
  input  dtiv_pkg::lane_res_t                to_i,
  output logic                               done_o,
  output logic signed [dtiv_pkg::DiffW-1:0]  day_difference_o,
  output logic                               invalid_date_o
);

  localparam int SW = dtiv_pkg::SerW;
  localparam int OW = dtiv_pkg::DiffW;
  localparam logic signed [SW:0] SatHi = (SW+1)'((1 << (OW-1)) - 1);
  localparam logic signed [SW:0] SatLo = -SatHi - (SW+1)'(1);

  logic signed [SW:0]   diff;
  logic signed [OW-1:0] diff_d;
  logic                 invalid_d;

  always_comb begin
    diff      = $signed({1'b0, to_i.serial}) - $signed({1'b0, from_i.serial});
    invalid_d = !(from_i.ok && to_i.ok);
    if (invalid_d) begin
      diff_d = '0;
    end else if (diff > SatHi) begin
      diff_d = OW'(SatHi);
    end else if (diff < SatLo) begin
      diff_d = OW'(SatLo);
    end else begin
      diff_d = OW'(diff);
    end
  end

  logic                 done_q;
  logic signed [OW-1:0] diff_q;
  logic                 invalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= from_i.valid && to_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q    <= diff_d;
    invalid_q <= invalid_d;
  end

  assign done_o           = done_q;
  assign day_difference_o = diff_q;
  assign invalid_date_o   = invalid_q;

endmodule

### rtl/dtiv_checker.sv
// Port-level checks of the date interval block.
module dtiv_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic [dtiv_pkg::YearW-1:0]         from_year_i,
  input logic [dtiv_pkg::MonthW-1:0]        from_month_i,
  input logic [dtiv_pkg::DayW-1:0]          from_day_i,
  input logic [dtiv_pkg::YearW-1:0]         to_year_i,
  input logic [dtiv_pkg::MonthW-1:0]        to_month_i,
  input logic [dtiv_pkg::DayW-1:0]          to_day_i,
  input logic                               done_o,
  input logic signed [dtiv_pkg::DiffW-1:0]  day_difference_o,
  input logic                               invalid_date_o
);

  // Every accepted item yields its result after both lane stages and the merge stage.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("result missing three cycles after an accepted item");

  // No result appears without a matching accepted item.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 3))
    else $error("result without a matching item");

  // An invalid date always comes with a zero difference.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && invalid_date_o) |-> (day_difference_o == '0))
    else $error("nonzero difference on an invalid item");

  // Identical dates are zero days apart.
  a_same_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && from_year_i == to_year_i &&
     from_month_i == to_month_i && from_day_i == to_day_i)
      |-> ##3 (day_difference_o == '0))
    else $error("identical dates gave a nonzero difference");

endmodule

bind date_interval_in_days dtiv_checker u_dtiv_checker (.*);
